>>> src/segx_pkg.sv
// package: payload types and fixed widths for the segment intersection core
`timescale 1ns / 1ps
package segx_pkg;

    // coordinate width and derived datapath widths
    localparam int COORD_BITS = 16;
    localparam int AW  = COORD_BITS + 1;        // line coefficient a, b
    localparam int PW  = 2 * COORD_BITS;        // coordinate product
    localparam int CW  = 2 * COORD_BITS + 1;    // line constant c
    localparam int SW  = 2 * COORD_BITS + 3;    // side value
    localparam int DW  = 2 * COORD_BITS + 3;    // determinant
    localparam int NW  = 3 * COORD_BITS + 3;    // crossing numerator
    localparam int QB  = COORD_BITS + 1;        // quotient bits kept
    localparam int QW  = COORD_BITS + 3;        // signed rounded quotient
    localparam int LAT = QB + 8;                // request to result, cycles

    typedef struct packed {
        logic signed [COORD_BITS-1:0] seg1_start_x;
        logic signed [COORD_BITS-1:0] seg1_start_y;
        logic signed [COORD_BITS-1:0] seg1_end_x;
        logic signed [COORD_BITS-1:0] seg1_end_y;
        logic signed [COORD_BITS-1:0] seg2_start_x;
        logic signed [COORD_BITS-1:0] seg2_start_y;
        logic signed [COORD_BITS-1:0] seg2_end_x;
        logic signed [COORD_BITS-1:0] seg2_end_y;
    } t_seg_req;

    typedef struct packed {
        logic                         hit;
        logic signed [COORD_BITS-1:0] cross_x;
        logic signed [COORD_BITS-1:0] cross_y;
    } t_seg_rsp;

    // closed range test of v against the span of p and q
    function automatic logic in_span(logic signed [QW-1:0] v,
                                     logic signed [COORD_BITS-1:0] p,
                                     logic signed [COORD_BITS-1:0] q);
        logic signed [QW-1:0] lo;
        logic signed [QW-1:0] hi;
        lo = (p < q) ? QW'(p) : QW'(q);
        hi = (p < q) ? QW'(q) : QW'(p);
        return (v >= lo) && (v <= hi);
    endfunction

endpackage

>>> src/segment_intersection_core.sv
// top level: fully pipelined segment pair intersection with rounded crossing point
// throughput: one request per cycle; busy is never raised, the divider is unrolled
//   into one restoring stage per quotient bit
// reset: synchronous active-low reset clears all valid bits; data registers are not reset
// the receiver cannot stall: each result is shown for exactly one cycle with o_valid
`timescale 1ns / 1ps
module segment_intersection_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  segx_pkg::t_seg_req  i_req,
    output logic                o_busy,
    output logic                o_valid,
    output segx_pkg::t_seg_rsp  o_rsp
);

    localparam int N   = segx_pkg::COORD_BITS;
    localparam int AW  = segx_pkg::AW;
    localparam int PW  = segx_pkg::PW;
    localparam int CW  = segx_pkg::CW;
    localparam int SW  = segx_pkg::SW;
    localparam int DW  = segx_pkg::DW;
    localparam int NW  = segx_pkg::NW;
    localparam int QB  = segx_pkg::QB;
    localparam int QW  = segx_pkg::QW;
    localparam int LAT = segx_pkg::LAT;

    // valid bits and request delay line
    logic               r_vld [0:LAT-1];
    segx_pkg::t_seg_req r_seg [0:QB+6];

    // stage 1: coefficients and coordinate products
    logic signed [AW-1:0] r_a1, r_b1, r_a2, r_b2;
    logic signed [PW-1:0] r_pc1, r_pc2, r_pc3, r_pc4;
    // stage 2
    logic signed [AW-1:0] r2_a1, r2_b1, r2_a2, r2_b2;
    logic signed [CW-1:0] r_c1, r_c2;
    logic signed [CW-1:0] r_ps1, r_ps2, r_ps3, r_ps4;
    logic signed [DW-2:0] r_pd1, r_pd2;
    // stage 3
    logic                 r_same;
    logic signed [DW-1:0] r_det;
    logic signed [NW-2:0] r_pn1, r_pn2, r_pm1, r_pm2;
    // stage 4
    logic signed [NW-1:0] r_nx, r_ny;
    logic [DW-1:0]        r_ud4;
    logic                 r_dneg;
    // stage 5
    logic [NW-1:0]        r_unx, r_uny;
    logic [DW-1:0]        r_ud5;
    // flags that ride along
    logic                 r_kill [3:QB+6];
    logic                 r_sx   [4:QB+6];
    logic                 r_sy   [4:QB+6];
    // divider stages
    logic [NW-1:0]        r_rx [0:QB];
    logic [NW-1:0]        r_ry [0:QB];
    logic [QB-1:0]        r_qx [0:QB];
    logic [QB-1:0]        r_qy [0:QB];
    logic [DW-1:0]        r_ud [0:QB];
    // rounding stage
    logic [QB:0]          r_qrx, r_qry;
    // output
    logic                 r_out_vld;
    segx_pkg::t_seg_rsp   r_rsp;

    logic signed [SW-1:0] n_s1, n_s2;
    logic                 n_ovf;
    logic signed [QW-1:0] n_vx, n_vy;
    logic                 n_hit;

    // valid shift line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_vld[k] <= 1'b0;
        end else begin
            r_vld[0] <= i_start;
            for (int k = 1; k < LAT; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // request delay line for the stage 2 side products and the final range test
    always_ff @(posedge i_clk) begin
        r_seg[0] <= i_req;
        for (int k = 1; k <= QB + 6; k++) r_seg[k] <= r_seg[k-1];
    end

    // stage 1: differences and cross products of end points
    always_ff @(posedge i_clk) begin
        r_a1  <= AW'(i_req.seg1_end_y) - AW'(i_req.seg1_start_y);
        r_b1  <= AW'(i_req.seg1_start_x) - AW'(i_req.seg1_end_x);
        r_a2  <= AW'(i_req.seg2_end_y) - AW'(i_req.seg2_start_y);
        r_b2  <= AW'(i_req.seg2_start_x) - AW'(i_req.seg2_end_x);
        r_pc1 <= i_req.seg1_start_y * i_req.seg1_end_x;
        r_pc2 <= i_req.seg1_start_x * i_req.seg1_end_y;
        r_pc3 <= i_req.seg2_start_y * i_req.seg2_end_x;
        r_pc4 <= i_req.seg2_start_x * i_req.seg2_end_y;
    end

    // stage 2: line constants, side products, determinant products
    always_ff @(posedge i_clk) begin
        r2_a1 <= r_a1;
        r2_b1 <= r_b1;
        r2_a2 <= r_a2;
        r2_b2 <= r_b2;
        r_c1  <= CW'(r_pc1) - CW'(r_pc2);
        r_c2  <= CW'(r_pc3) - CW'(r_pc4);
        r_ps1 <= r_a1 * r_seg[0].seg2_start_x;
        r_ps2 <= r_b1 * r_seg[0].seg2_start_y;
        r_ps3 <= r_a1 * r_seg[0].seg2_end_x;
        r_ps4 <= r_b1 * r_seg[0].seg2_end_y;
        r_pd1 <= r_a2 * r_b1;
        r_pd2 <= r_a1 * r_b2;
    end

    // side values of segment 2 end points against line 1
    always_comb begin
        n_s1 = SW'(r_ps1) + SW'(r_ps2) + SW'(r_c1);
        n_s2 = SW'(r_ps3) + SW'(r_ps4) + SW'(r_c1);
    end

    // stage 3: same-side test, determinant, numerator products
    always_ff @(posedge i_clk) begin
        r_same <= ((n_s1 > 0) && (n_s2 > 0)) || (n_s1[SW-1] && n_s2[SW-1]);
        r_det  <= DW'(r_pd1) - DW'(r_pd2);
        r_pn1  <= r_c1 * r2_b2;
        r_pn2  <= r_c2 * r2_b1;
        r_pm1  <= r_c2 * r2_a1;
        r_pm2  <= r_c1 * r2_a2;
    end

    // stage 4: numerators and determinant magnitude
    always_ff @(posedge i_clk) begin
        r_nx      <= NW'(r_pn1) - NW'(r_pn2);
        r_ny      <= NW'(r_pm1) - NW'(r_pm2);
        r_ud4     <= r_det[DW-1] ? DW'(-r_det) : DW'(r_det);
        r_dneg    <= r_det[DW-1];
        r_kill[3] <= r_same || (r_det == '0);
    end

    // stage 5: numerator magnitudes and quotient signs
    always_ff @(posedge i_clk) begin
        r_unx     <= r_nx[NW-1] ? NW'(-r_nx) : NW'(r_nx);
        r_uny     <= r_ny[NW-1] ? NW'(-r_ny) : NW'(r_ny);
        r_ud5     <= r_ud4;
        r_sx[4]   <= r_nx[NW-1] ^ r_dneg;
        r_sy[4]   <= r_ny[NW-1] ^ r_dneg;
        r_kill[4] <= r_kill[3];
    end

    // quotient too large for any coordinate means no hit
    always_comb begin
        n_ovf = ({1'b0, r_unx} >= {r_ud5, {QB{1'b0}}}) ||
                ({1'b0, r_uny} >= {r_ud5, {QB{1'b0}}});
    end

    // stage 6: divider load
    always_ff @(posedge i_clk) begin
        r_rx[0]   <= r_unx;
        r_ry[0]   <= r_uny;
        r_qx[0]   <= '0;
        r_qy[0]   <= '0;
        r_ud[0]   <= r_ud5;
        r_sx[5]   <= r_sx[4];
        r_sy[5]   <= r_sy[4];
        r_kill[5] <= r_kill[4] || n_ovf;
    end

    // restoring divider, one quotient bit per stage, most significant first
    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int SH = QB - 1 - j;
        logic [NW:0] w_tr;
        logic        w_gex, w_gey;
        assign w_tr  = {{(NW + 1 - DW){1'b0}}, r_ud[j]} << SH;
        assign w_gex = {1'b0, r_rx[j]} >= w_tr;
        assign w_gey = {1'b0, r_ry[j]} >= w_tr;
        always_ff @(posedge i_clk) begin
            r_rx[j+1] <= w_gex ? NW'({1'b0, r_rx[j]} - w_tr) : r_rx[j];
            r_ry[j+1] <= w_gey ? NW'({1'b0, r_ry[j]} - w_tr) : r_ry[j];
            r_qx[j+1] <= r_qx[j] | (QB'(w_gex) << SH);
            r_qy[j+1] <= r_qy[j] | (QB'(w_gey) << SH);
            r_ud[j+1] <= r_ud[j];
            r_sx[6+j]   <= r_sx[5+j];
            r_sy[6+j]   <= r_sy[5+j];
            r_kill[6+j] <= r_kill[5+j];
        end
    end

    // rounding stage: round half away from zero on the magnitude
    always_ff @(posedge i_clk) begin
        r_qrx <= (QB+1)'(r_qx[QB]) +
                 (QB+1)'({r_rx[QB][DW-1:0], 1'b0} >= {1'b0, r_ud[QB]});
        r_qry <= (QB+1)'(r_qy[QB]) +
                 (QB+1)'({r_ry[QB][DW-1:0], 1'b0} >= {1'b0, r_ud[QB]});
        r_sx[QB+6]   <= r_sx[QB+5];
        r_sy[QB+6]   <= r_sy[QB+5];
        r_kill[QB+6] <= r_kill[QB+5];
    end

    // signed point and range test against both segments
    always_comb begin
        n_vx  = r_sx[QB+6] ? -QW'(r_qrx) : QW'(r_qrx);
        n_vy  = r_sy[QB+6] ? -QW'(r_qry) : QW'(r_qry);
        n_hit = !r_kill[QB+6] &&
                segx_pkg::in_span(n_vx, r_seg[QB+6].seg1_start_x, r_seg[QB+6].seg1_end_x) &&
                segx_pkg::in_span(n_vx, r_seg[QB+6].seg2_start_x, r_seg[QB+6].seg2_end_x) &&
                segx_pkg::in_span(n_vy, r_seg[QB+6].seg1_start_y, r_seg[QB+6].seg1_end_y) &&
                segx_pkg::in_span(n_vy, r_seg[QB+6].seg2_start_y, r_seg[QB+6].seg2_end_y);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vld[LAT-2];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp.hit     <= n_hit;
        r_rsp.cross_x <= n_hit ? n_vx[N-1:0] : '0;
        r_rsp.cross_y <= n_hit ? n_vy[N-1:0] : '0;
    end

    assign o_busy  = 1'b0;
    assign o_valid = r_out_vld & r_vld[LAT-1];
    assign o_rsp   = r_rsp;

endmodule

>>> src/segx_checker.sv
// checker: port-level properties of the segment intersection core, bound to the top level
`timescale 1ns / 1ps
module segx_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               o_busy,
    input logic               o_valid,
    input segx_pkg::t_seg_rsp o_rsp
);

    // every request yields its result after the fixed latency
    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ##(segx_pkg::LAT) o_valid)
        else $error("request without result");

    // no result without a request at the fixed latency before
    a_lat_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, segx_pkg::LAT))
        else $error("result without request");

    // a miss reports the origin
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_rsp.hit) |-> (o_rsp.cross_x == '0 && o_rsp.cross_y == '0))
        else $error("miss with nonzero point");

    // the pipeline never pushes back
    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy)
        else $error("busy raised");

endmodule

bind segment_intersection_core segx_checker u_segx_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_valid (o_valid),
    .o_rsp   (o_rsp)
);

>>> dv/testbench.sv
// testbench: segment intersection core checked against an exact crossing predictor
`timescale 1ns / 1ps
module testbench;

    localparam int CB = segx_pkg::COORD_BITS;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    segx_pkg::t_seg_req i_req;
    logic               o_busy;
    logic               o_valid;
    segx_pkg::t_seg_rsp o_rsp;

    segx_pkg::t_seg_rsp crossings_due[$];
    int       error_count;
    int       request_count;
    int       hit_count;
    bit       quiet_phase;

    segment_intersection_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_req   (i_req),
        .o_busy  (o_busy),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // n / d rounded half away from zero
    function automatic logic signed [127:0] div_round(logic signed [127:0] n,
                                                      logic signed [127:0] d);
        logic signed [127:0] un;
        logic signed [127:0] ud;
        logic signed [127:0] q;
        logic signed [127:0] r;
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        q = un / ud;
        r = un % ud;
        if (2 * r >= ud) q = q + 1;
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic bit in_range(logic signed [127:0] v, logic signed [127:0] p,
                                    logic signed [127:0] q);
        return (v >= ((p < q) ? p : q)) && (v <= ((p < q) ? q : p));
    endfunction

    // exact crossing of two segments
    function automatic segx_pkg::t_seg_rsp predict_crossing(segx_pkg::t_seg_req r);
        logic signed [127:0] x1a, y1a, x1b, y1b, x2a, y2a, x2b, y2b;
        logic signed [127:0] la, lb, lc, ma, mb, mc, s1, s2, det, px, py;
        segx_pkg::t_seg_rsp res;
        res = '0;
        x1a = 128'(r.seg1_start_x); y1a = 128'(r.seg1_start_y);
        x1b = 128'(r.seg1_end_x);   y1b = 128'(r.seg1_end_y);
        x2a = 128'(r.seg2_start_x); y2a = 128'(r.seg2_start_y);
        x2b = 128'(r.seg2_end_x);   y2b = 128'(r.seg2_end_y);
        la = y1b - y1a;
        lb = x1a - x1b;
        lc = y1a * x1b - x1a * y1b;
        s1 = la * x2a + lb * y2a + lc;
        s2 = la * x2b + lb * y2b + lc;
        if ((s1 > 0 && s2 > 0) || (s1 < 0 && s2 < 0)) return res;
        ma = y2b - y2a;
        mb = x2a - x2b;
        mc = y2a * x2b - x2a * y2b;
        det = ma * lb - la * mb;
        if (det == 0) return res;
        px = div_round(lc * mb - mc * lb, det);
        py = div_round(mc * la - lc * ma, det);
        if (in_range(px, x1a, x1b) && in_range(px, x2a, x2b) &&
            in_range(py, y1a, y1b) && in_range(py, y2a, y2b)) begin
            res.hit = 1'b1;
            res.cross_x = px[CB-1:0];
            res.cross_y = py[CB-1:0];
        end
        return res;
    endfunction

    // send one request, with random gaps outside quiet phases
    task automatic send_request(segx_pkg::t_seg_req r);
        while (!quiet_phase && $urandom_range(99) < 23) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_req   <= r;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        crossings_due.push_back(predict_crossing(r));
        request_count++;
        @(negedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        segx_pkg::t_seg_rsp want;
        if (i_rst_n && o_valid) begin
            if (crossings_due.size() == 0) begin
                $error("result with nothing expected");
                error_count++;
            end else begin
                want = crossings_due.pop_front();
                if (o_rsp.hit !== want.hit) begin
                    $error("hit expected %0d got %0d", want.hit, o_rsp.hit);
                    error_count++;
                end
                if (o_rsp.cross_x !== want.cross_x) begin
                    $error("cross_x expected %0d got %0d", want.cross_x, o_rsp.cross_x);
                    error_count++;
                end
                if (o_rsp.cross_y !== want.cross_y) begin
                    $error("cross_y expected %0d got %0d", want.cross_y, o_rsp.cross_y);
                    error_count++;
                end
                if (o_rsp.hit === 1'b1) hit_count++;
            end
        end
    end

    function automatic segx_pkg::t_seg_req make_req(int ax, int ay, int bx, int by,
                                                    int cx, int cy, int dx, int dy);
        segx_pkg::t_seg_req r;
        r.seg1_start_x = CB'(ax); r.seg1_start_y = CB'(ay);
        r.seg1_end_x   = CB'(bx); r.seg1_end_y   = CB'(by);
        r.seg2_start_x = CB'(cx); r.seg2_start_y = CB'(cy);
        r.seg2_end_x   = CB'(dx); r.seg2_end_y   = CB'(dy);
        return r;
    endfunction

    function automatic int rand_coord(int span);
        if (span == 0) return int'($urandom_range((1 << CB) - 1)) - (1 << (CB - 1));
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // hand-picked corner cases
    task automatic test_directed();
        send_request(make_req(-10, 0, 10, 0, 0, -10, 0, 10));
        send_request(make_req(0, 0, 3, 1, 1, 0, 0, 1));
        send_request(make_req(0, 0, 10, 0, 0, 5, 10, 5));
        send_request(make_req(0, 0, 10, 0, 0, 5, 10, 6));
        send_request(make_req(0, 0, 10, 0, 2, 0, 8, 0));
        send_request(make_req(0, 0, 10, 10, 10, 0, 0, 10));
        send_request(make_req(0, 0, 10, 0, 10, 0, 10, 10));
        send_request(make_req(3, 3, 3, 3, 3, 3, 3, 3));
        send_request(make_req(0, 0, 1, 0, 5, -5, 5, 5));
        send_request(make_req(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        send_request(make_req(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
        send_request(make_req(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767));
        send_request(make_req(-32768, -32768, -32768, 32767, -32768, -32768, 32767, -32768));
        send_request(make_req(0, 0, 1, 2, 1, 0, 0, 1));
        send_request(make_req(0, 0, -1, -2, -1, 0, 0, -1));
        send_request(make_req(-1, -1, -1, -1, -1, -1, -1, -1));
        send_request(make_req(0, 0, 0, 0, 0, 0, 0, 0));
    endtask

    // random pairs: narrow spans, half of them mirrored to cross, and some wide noise
    task automatic test_random(int n);
        segx_pkg::t_seg_req r;
        int span;
        int cx, cy;
        for (int k = 0; k < n; k++) begin
            quiet_phase = (k >= n / 3) && (k < n / 3 + 150);
            span = ($urandom_range(3) == 0) ? 0 : (($urandom_range(1)) ? 40 : 8000);
            r = make_req(rand_coord(span), rand_coord(span), rand_coord(span),
                         rand_coord(span), rand_coord(span), rand_coord(span),
                         rand_coord(span), rand_coord(span));
            if (span != 0 && $urandom_range(1)) begin
                // mirror segment 2 through the truncated midpoint of segment 1 so they tend to cross
                cx = (int'(r.seg1_start_x) + int'(r.seg1_end_x)) / 2;
                cy = (int'(r.seg1_start_y) + int'(r.seg1_end_y)) / 2;
                r.seg2_end_x = CB'(2 * cx - int'(r.seg2_start_x));
                r.seg2_end_y = CB'(2 * cy - int'(r.seg2_start_y));
            end
            send_request(r);
        end
        quiet_phase = 1'b0;
    endtask

    initial begin
        error_count = 0;
        request_count = 0;
        hit_count = 0;
        quiet_phase = 1'b0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_req   = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(1630);
        i_start <= 1'b0;
        while (crossings_due.size() != 0) @(posedge i_clk);
        repeat (segx_pkg::LAT + 5) @(posedge i_clk);
        $display("sent %0d segment pairs, %0d crossings reported", request_count, hit_count);
        if (error_count == 0 && crossings_due.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // timeout
    initial begin
        #5ms;
        $display("testbench: done, errors");
        $finish;
    end
endmodule

>>> files.f
src/segx_pkg.sv
src/segment_intersection_core.sv
src/segx_checker.sv
dv/testbench.sv
